### design/ffba_pkg.sv
`timescale 1ns / 1ps

package ffba_pkg;

	// Field widths of the command and response beats.
	localparam int CMD_W    = 1;
	localparam int SIZE_W   = 16;
	localparam int ADDR_W   = 16;
	localparam int OFFSET_W = 16;
	localparam int STATUS_W = 2;
	localparam int FCOUNT_W = 11;

	// Width of the divider operand: a 16-bit size plus up to 4095 of rounding.
	localparam int DIV_W = 17;

	localparam int MIN_REQUEST_BYTES = 4;

	localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
	localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_SIZE    = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NOSPACE = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_BADFREE = 2'd3;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_SCAN,
		ST_MARK,
		ST_FREE_RD,
		ST_FREE_CHK,
		ST_UNMARK,
		ST_DONE
	} ffba_state_t;

endpackage

### design/ffba_cmd_if.sv
`timescale 1ns / 1ps

interface ffba_cmd_if;
	import ffba_pkg::*;

	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [SIZE_W-1:0] size_bytes;
	logic [ADDR_W-1:0] free_address;

	modport source (output valid, output command, output size_bytes, output free_address,
		input ready);
	modport sink (input valid, input command, input size_bytes, input free_address,
		output ready);
endinterface

### design/ffba_rsp_if.sv
`timescale 1ns / 1ps

interface ffba_rsp_if;
	import ffba_pkg::*;

	logic                valid;
	logic                ready;
	logic [OFFSET_W-1:0] result_offset;
	logic [STATUS_W-1:0] status;
	logic [FCOUNT_W-1:0] free_block_count;

	modport source (output valid, output result_offset, output status,
		output free_block_count, input ready);
	modport sink (input valid, input result_offset, input status,
		input free_block_count, output ready);
endinterface

### design/first_fit_block_allocator.sv
`timescale 1ns / 1ps

// Channel | Dir | Beat contents                                 | Handshake
// cmd     | in  | command, size_bytes, free_address             | valid / ready
// rsp     | out | result_offset, status, free_block_count       | valid / ready
//
// After reset the map is cleared one entry per cycle, all NUM_BLOCKS of them, while cmd.ready is low.
// An allocate runs the divider, a first-fit map scan and the marking of the run; a rejected
// size goes straight to the finish state. A free runs the divider, reads and checks the head
// entry and clears its run (a refused one ends after divider or check); the write port sets the pace.
// One command is in flight at a time; the response register lets the next command be taken
// while the last response beat still waits, and a stalled rsp only holds the finish state.
module first_fit_block_allocator #(
	parameter int BLOCK_BYTES       = 64,
	parameter int NUM_BLOCKS        = 1024,
	parameter int MAX_REQUEST_BYTES = 4096
) (
	input logic       clk,
	input logic       arst_n,
	ffba_cmd_if.sink   cmd,
	ffba_rsp_if.source rsp
);
	import ffba_pkg::*;

	// Longest run one allocate can ask for, and the widths that follow from it.
	localparam int MAX_NEED = (MAX_REQUEST_BYTES + BLOCK_BYTES - 1) / BLOCK_BYTES;
	localparam int NEED_W   = $clog2(MAX_NEED + 1);
	// Map entry codes: zero is free, 1..MAX_NEED is a run head, all ones is continuation.
	localparam int MAP_W    = $clog2(MAX_NEED + 2);
	localparam int IDX_W    = $clog2(NUM_BLOCKS);
	localparam int CNT_W    = $clog2(NUM_BLOCKS + 1);
	localparam int REM_W    = $clog2(BLOCK_BYTES);

	localparam logic [MAP_W-1:0] MAP_CONT = '1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BLOCKS - 1);

	ffba_state_t state_q, state_d;

	// Control registers.
	logic [IDX_W-1:0] ptr_q;
	logic [CNT_W-1:0] free_q;
	logic             issue_q;
	logic             chk_vld_q;
	logic             rsp_valid_q;

	// Working registers of the current command.
	logic [CMD_W-1:0]    cmd_q;
	logic [STATUS_W-1:0] status_q;
	logic [NEED_W-1:0]   need_q;
	logic [NEED_W-1:0]   run_q;
	logic [NEED_W-1:0]   cnt_q;
	logic [IDX_W-1:0]    scan_idx_q;
	logic [IDX_W-1:0]    chk_idx_q;
	logic [IDX_W-1:0]    head_q;
	logic [OFFSET_W-1:0] offset_q;

	// Response register.
	logic [OFFSET_W-1:0] rsp_offset_q;
	logic [STATUS_W-1:0] rsp_status_q;
	logic [FCOUNT_W-1:0] rsp_count_q;

	// Map port signals.
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic [MAP_W-1:0] rd_data;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [MAP_W-1:0] wr_data;

	// Divider signals.
	logic             div_start;
	logic [DIV_W-1:0] div_dividend;
	logic             div_done;
	logic [DIV_W-1:0] div_quo;
	logic [REM_W-1:0] div_rem;

	logic                      size_bad;
	logic                      free_bad;
	logic [NEED_W-1:0]         run_d;
	logic                      scan_hit;
	logic                      scan_miss;
	logic [IDX_W:0]            head_wide;
	logic                      entry_bad;
	logic                      load_rsp;
	logic [CNT_W+FCOUNT_W-1:0] free_ext;

	ffba_map_mem #(
		.DEPTH (NUM_BLOCKS),
		.WIDTH (MAP_W)
	) u_map (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// The same divider rounds a size up to blocks and splits a free address into
	// block index and misalignment.
	ffba_div #(
		.DIVISOR (BLOCK_BYTES),
		.DW      (DIV_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	assign size_bad = (DIV_W'(cmd.size_bytes) < DIV_W'(MIN_REQUEST_BYTES)) ||
		(DIV_W'(cmd.size_bytes) > DIV_W'(MAX_REQUEST_BYTES));
	assign div_dividend = (cmd.command == CMD_ALLOC) ?
		DIV_W'(cmd.size_bytes) + DIV_W'(BLOCK_BYTES - 1) : DIV_W'(cmd.free_address);
	assign free_bad = (div_rem != '0) || (div_quo >= DIV_W'(NUM_BLOCKS));

	// First-fit run tracking: the entry read last cycle extends or breaks the run.
	assign run_d     = (rd_data == '0) ? run_q + NEED_W'(1) : '0;
	assign scan_hit  = chk_vld_q && (run_d == need_q);
	assign scan_miss = chk_vld_q && !scan_hit && (chk_idx_q == LAST_IDX);
	assign head_wide = {1'b0, chk_idx_q} + (IDX_W+1)'(1) - (IDX_W+1)'(need_q);

	// Only a run head may be freed.
	assign entry_bad = (rd_data == '0) || (rd_data == MAP_CONT);

	always_comb begin
		state_d   = state_q;
		rd_en     = 1'b0;
		rd_addr   = scan_idx_q;
		wr_en     = 1'b0;
		wr_addr   = ptr_q;
		wr_data   = '0;
		div_start = 1'b0;
		load_rsp  = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				wr_en = 1'b1;
				if (ptr_q == LAST_IDX)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (cmd.valid) begin
					if ((cmd.command == CMD_ALLOC) && size_bad) begin
						state_d = ST_DONE;
					end else begin
						div_start = 1'b1;
						state_d   = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				if (div_done) begin
					if (cmd_q == CMD_ALLOC)
						state_d = ST_SCAN;
					else if (free_bad)
						state_d = ST_DONE;
					else
						state_d = ST_FREE_RD;
				end
			end
			ST_SCAN: begin
				rd_en = issue_q;
				if (scan_hit)
					state_d = ST_MARK;
				else if (scan_miss)
					state_d = ST_DONE;
			end
			ST_MARK: begin
				wr_en   = 1'b1;
				wr_data = (ptr_q == head_q) ? MAP_W'(need_q) : MAP_CONT;
				if (cnt_q == NEED_W'(1))
					state_d = ST_DONE;
			end
			ST_FREE_RD: begin
				rd_en   = 1'b1;
				rd_addr = ptr_q;
				state_d = ST_FREE_CHK;
			end
			ST_FREE_CHK: begin
				state_d = entry_bad ? ST_DONE : ST_UNMARK;
			end
			ST_UNMARK: begin
				wr_en = 1'b1;
				if (cnt_q == NEED_W'(1))
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					load_rsp = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			ptr_q       <= '0;
			free_q      <= CNT_W'(NUM_BLOCKS);
			issue_q     <= 1'b0;
			chk_vld_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_CLEAR: begin
					ptr_q <= ptr_q + IDX_W'(1);
				end
				ST_DIV: begin
					issue_q   <= div_done && (cmd_q == CMD_ALLOC);
					chk_vld_q <= 1'b0;
					if (div_done)
						ptr_q <= IDX_W'(div_quo);
				end
				ST_SCAN: begin
					chk_vld_q <= issue_q;
					if (issue_q && (scan_idx_q == LAST_IDX))
						issue_q <= 1'b0;
					if (scan_hit) begin
						issue_q   <= 1'b0;
						chk_vld_q <= 1'b0;
						ptr_q     <= head_wide[IDX_W-1:0];
						free_q    <= free_q - CNT_W'(need_q);
					end
				end
				ST_MARK, ST_UNMARK: begin
					ptr_q <= ptr_q + IDX_W'(1);
				end
				ST_FREE_CHK: begin
					if (!entry_bad)
						free_q <= free_q + CNT_W'(rd_data);
				end
				default: begin
				end
			endcase
			if (load_rsp)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cmd_q    <= cmd.command;
				offset_q <= '0;
				status_q <= ((cmd.command == CMD_ALLOC) && size_bad) ? STATUS_SIZE : STATUS_OK;
			end
			ST_DIV: begin
				need_q     <= NEED_W'(div_quo);
				run_q      <= '0;
				scan_idx_q <= '0;
				if (div_done && (cmd_q == CMD_FREE) && free_bad)
					status_q <= STATUS_BADFREE;
			end
			ST_SCAN: begin
				if (issue_q)
					scan_idx_q <= scan_idx_q + IDX_W'(1);
				chk_idx_q <= scan_idx_q;
				if (chk_vld_q)
					run_q <= run_d;
				if (scan_hit) begin
					head_q <= head_wide[IDX_W-1:0];
					cnt_q  <= need_q;
				end else if (scan_miss) begin
					status_q <= STATUS_NOSPACE;
				end
			end
			ST_MARK: begin
				cnt_q    <= cnt_q - NEED_W'(1);
				offset_q <= OFFSET_W'(32'(head_q) * 32'(BLOCK_BYTES));
			end
			ST_FREE_CHK: begin
				if (entry_bad)
					status_q <= STATUS_BADFREE;
				else
					cnt_q <= NEED_W'(rd_data);
			end
			ST_UNMARK: begin
				cnt_q <= cnt_q - NEED_W'(1);
			end
			default: begin
			end
		endcase
	end

	// The reported count keeps the low bits of the free-block counter.
	assign free_ext = (CNT_W+FCOUNT_W)'(free_q);

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_offset_q <= offset_q;
			rsp_status_q <= status_q;
			rsp_count_q  <= free_ext[FCOUNT_W-1:0];
		end
	end

	assign cmd.ready            = (state_q == ST_IDLE);
	assign rsp.valid            = rsp_valid_q;
	assign rsp.result_offset    = rsp_offset_q;
	assign rsp.status           = rsp_status_q;
	assign rsp.free_block_count = rsp_count_q;
endmodule

### design/ffba_div.sv
`timescale 1ns / 1ps

// Division by a constant through a multiply by its rounded-up reciprocal. The quotient
// is exact for every dividend of DW bits. The remainder comes from a multiply back and
// a subtract in the cycle after the quotient, and done rises together with the remainder.
module ffba_div #(
	parameter int DIVISOR = 64,
	parameter int DW      = 17
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [DW-1:0]                dividend,
	output logic                         done,
	output logic [DW-1:0]                quotient,
	output logic [$clog2(DIVISOR)-1:0]   remainder
);
	localparam int LW = $clog2(DIVISOR);
	localparam int SH = DW + LW;
	localparam int MW = DW + 1;
	localparam int PW = DW + MW;
	localparam longint unsigned RECIP =
		((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
	localparam logic [MW-1:0] RECIP_M = MW'(RECIP);

	logic          vld_s1;
	logic          vld_s2;
	logic          done_q;
	logic [DW-1:0] num_q;
	logic [DW-1:0] quo_q;
	logic [LW-1:0] rem_q;
	logic [PW-1:0] prod;
	logic [DW-1:0] back;
	logic [DW-1:0] diff;

	assign prod = PW'(num_q) * PW'(RECIP_M);
	assign back = quo_q * DW'(DIVISOR);
	assign diff = num_q - back;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			done_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (start)
			num_q <= dividend;
		if (vld_s1)
			quo_q <= DW'(prod[PW-1:SH]);
		if (vld_s2)
			rem_q <= diff[LW-1:0];
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule

### design/ffba_map_mem.sv
`timescale 1ns / 1ps

// Allocation map storage: one write port, one read port with registered data.
module ffba_map_mem #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 7
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;
endmodule
